[src/spiq_pkg.sv]
// Package: shared constants, codes and types of the stable priority insert queue.
package spiq_pkg;

  localparam int unsigned QUEUE_DEPTH    = 16;
  localparam int unsigned PRIORITY_WIDTH = 8;
  localparam int unsigned PAYLOAD_WIDTH  = 32;
  localparam int unsigned COUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_APPEND      = 3'd0,
    OP_INSERT      = 3'd1,
    OP_REMOVE_HEAD = 3'd2,
    OP_REMOVE_TAIL = 3'd3,
    OP_PEEK        = 3'd4
  } spiq_op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spiq_status_t;

  // One queue slot as seen by its neighbours.
  typedef struct packed {
    logic                      occ;
    logic [PRIORITY_WIDTH-1:0] prio;
    logic [PAYLOAD_WIDTH-1:0]  payload;
  } spiq_entry_t;

  // Operation broadcast to every cell; push and pops are already gated by full/empty.
  typedef struct packed {
    logic                      push;
    logic                      by_prio;
    logic                      pop_head;
    logic                      pop_tail;
    logic [PRIORITY_WIDTH-1:0] prio;
    logic [PAYLOAD_WIDTH-1:0]  payload;
  } spiq_cmd_t;

endpackage

[src/spiq_cell.sv]
// Cell: one queue slot that shifts towards the head or the tail with its neighbours.
module spiq_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spiq_pkg::spiq_cmd_t   cmd,
  input  spiq_pkg::spiq_entry_t left_ent,
  input  spiq_pkg::spiq_entry_t right_ent,
  input  logic                 seen_in,
  output logic                 seen_out,
  output spiq_pkg::spiq_entry_t ent,
  output logic                 is_tail
);
  import spiq_pkg::*;

  logic                      occ_r, occ_nxt;
  logic [PRIORITY_WIDTH-1:0] prio_r, prio_nxt;
  logic [PAYLOAD_WIDTH-1:0]  payload_r, payload_nxt;
  logic                      mark;

  // Candidate slot: first free slot, or for an insert the first one holding a greater priority.
  assign mark     = !occ_r || (cmd.by_prio && (prio_r > cmd.prio));
  assign seen_out = seen_in || mark;

  assign ent.occ     = occ_r;
  assign ent.prio    = prio_r;
  assign ent.payload = payload_r;
  assign is_tail     = occ_r && !right_ent.occ;

  always_comb begin
    occ_nxt     = occ_r;
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    priority if (cmd.push) begin
      if (seen_in) begin
        // shift one place towards the tail
        occ_nxt     = left_ent.occ;
        prio_nxt    = left_ent.prio;
        payload_nxt = left_ent.payload;
      end else if (mark) begin
        occ_nxt     = 1'b1;
        prio_nxt    = cmd.prio;
        payload_nxt = cmd.payload;
      end
    end else if (cmd.pop_head) begin
      occ_nxt     = right_ent.occ;
      prio_nxt    = right_ent.prio;
      payload_nxt = right_ent.payload;
    end else if (cmd.pop_tail) begin
      occ_nxt = occ_r && right_ent.occ;
    end else begin
      // hold the slot
      occ_nxt = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    payload_r <= payload_nxt;
  end

endmodule

[src/stable_priority_insert_queue_unit.sv]
// Top level: bounded ordered queue of (priority, payload) entries built as a chain of cells.
//
// Use: drive in_opcode, in_item_priority and in_item_payload with start high; the
// item is taken at a rising edge where start is high and busy is low. Opcodes:
// append at tail, priority insert (before the first entry with a strictly greater
// priority, so equal priorities keep arrival order), remove head, remove tail and
// peek; unused codes act as peek.
// Every item gives exactly one result: out_valid is high for one cycle, the cycle
// after acceptance, with status, head and tail entries (zero when empty) and the
// entry count after the operation. The receiver cannot stall; sample on the strobe.
// Throughput: one item per cycle while busy is low. The slot chosen for an insert
// is set in the cycle of acceptance by the compare in every cell and the ripple of
// the "seen" flag along the chain of QUEUE_DEPTH cells.
// A push to a full queue is dropped with status full; a removal from an empty queue
// changes nothing and reports status empty.
// Reset (synchronous, active low) empties the queue and holds busy high while it is
// asserted and through the first cycle after it is released.
module stable_priority_insert_queue_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          in_opcode,
  input  logic [spiq_pkg::PRIORITY_WIDTH-1:0] in_item_priority,
  input  logic [spiq_pkg::PAYLOAD_WIDTH-1:0]  in_item_payload,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic                                out_head_valid,
  output logic [spiq_pkg::PRIORITY_WIDTH-1:0] out_head_priority,
  output logic [spiq_pkg::PAYLOAD_WIDTH-1:0]  out_head_payload,
  output logic [spiq_pkg::PRIORITY_WIDTH-1:0] out_tail_priority,
  output logic [spiq_pkg::PAYLOAD_WIDTH-1:0]  out_tail_payload,
  output logic [spiq_pkg::COUNT_WIDTH-1:0]    out_entry_total
);
  import spiq_pkg::*;

  logic                   busy_r;
  logic                   accept;
  logic                   full, empty;
  logic                   want_push, want_pop, is_insert, is_pop_head;
  spiq_cmd_t              cmd;
  spiq_status_t           status_nxt;
  logic                   out_valid_r;
  spiq_status_t           status_r;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  spiq_entry_t            ents      [QUEUE_DEPTH];
  spiq_entry_t            left_ents [QUEUE_DEPTH];
  spiq_entry_t            right_ents[QUEUE_DEPTH];
  logic                   tail_sel  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   seen;

  // Hold off items during reset and until the registered busy flag clears after it.
  assign busy   = busy_r || !rst_n;
  assign accept = start && !busy;

  // Cells stay packed from the head, so the ends of the chain give full and empty.
  assign full  = ents[QUEUE_DEPTH-1].occ;
  assign empty = !ents[0].occ;

  // Decode the opcode; unused codes behave as peek.
  always_comb begin
    want_push   = 1'b0;
    want_pop    = 1'b0;
    is_insert   = 1'b0;
    is_pop_head = 1'b0;
    unique case (in_opcode)
      OP_APPEND: begin
        want_push = 1'b1;
      end
      OP_INSERT: begin
        want_push = 1'b1;
        is_insert = 1'b1;
      end
      OP_REMOVE_HEAD: begin
        want_pop    = 1'b1;
        is_pop_head = 1'b1;
      end
      OP_REMOVE_TAIL: begin
        want_pop = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Broadcast the gated operation to every cell and work out status and count.
  always_comb begin
    cmd.push     = accept && want_push && !full;
    cmd.by_prio  = is_insert;
    cmd.pop_head = accept && want_pop && is_pop_head && !empty;
    cmd.pop_tail = accept && want_pop && !is_pop_head && !empty;
    cmd.prio     = in_item_priority;
    cmd.payload  = in_item_payload;

    priority if (want_push && full) begin
      status_nxt = ST_FULL;
    end else if (want_pop && empty) begin
      status_nxt = ST_EMPTY;
    end else begin
      status_nxt = ST_DONE;
    end

    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + COUNT_WIDTH'(1);
    end else if (cmd.pop_head || cmd.pop_tail) begin
      count_nxt = count_r - COUNT_WIDTH'(1);
    end
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_ents[i] = '0;
    end else begin : g_mid_l
      assign left_ents[i] = ents[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_ents[i] = '0;
    end else begin : g_mid_r
      assign right_ents[i] = ents[i+1];
    end

    spiq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_ent  (left_ents[i]),
      .right_ent (right_ents[i]),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .ent       (ents[i]),
      .is_tail   (tail_sel[i])
    );
  end

  // Tail is the one occupied cell whose neighbour is free: a one-hot OR across the row.
  always_comb begin
    out_tail_priority = '0;
    out_tail_payload  = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      out_tail_priority = out_tail_priority | (ents[i].prio & {PRIORITY_WIDTH{tail_sel[i]}});
      out_tail_payload  = out_tail_payload  | (ents[i].payload & {PAYLOAD_WIDTH{tail_sel[i]}});
    end
  end

  // Head straight from the first cell, forced to zero when empty.
  assign out_head_valid    = ents[0].occ;
  assign out_head_priority = ents[0].prio & {PRIORITY_WIDTH{ents[0].occ}};
  assign out_head_payload  = ents[0].payload & {PAYLOAD_WIDTH{ents[0].occ}};
  assign out_entry_total   = count_r;
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      count_r     <= count_nxt;
    end
  end

  // Status needs no reset: it is only looked at with the strobe.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

endmodule

[src/spiq_checker.sv]
// Checker: port-level properties of the queue, bound to the top level.
module spiq_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic [1:0]                          out_status,
  input logic                                out_head_valid,
  input logic [spiq_pkg::COUNT_WIDTH-1:0]    out_entry_total
);
  import spiq_pkg::*;

  // Every accepted item gives its result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("accepted item gave no result");

  // No result without an item.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result strobe without an accepted item");

  // Head valid agrees with the count.
  a_head_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_head_valid == (out_entry_total != '0)))
    else $error("head valid disagrees with entry count");

  // A dropped push only happens on a full queue.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_total == COUNT_WIDTH'(QUEUE_DEPTH))
    else $error("full status with room left");

  // An empty report leaves the queue empty.
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entry_total == '0)
    else $error("empty status with entries held");

endmodule

bind stable_priority_insert_queue_unit spiq_checker u_spiq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_head_valid  (out_head_valid),
  .out_entry_total (out_entry_total)
);

[verif/tb_stable_priority_insert_queue_unit.sv]
// Testbench for the stable priority insert queue: directed and random items checked on a model.
`timescale 1ns / 100ps

module tb_stable_priority_insert_queue_unit;
  import spiq_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no item and no result
  localparam int unsigned MAX_GAP        = 6;     // longest single idle gap; the sender may draw several in a row
  localparam int unsigned PHASE_ITEMS    = 460;   // random items per idling phase
  localparam int unsigned SETTLE_CYCLES  = 3;     // settle margin after the last result
  localparam logic [PRIORITY_WIDTH-1:0] PRIO_MAX = {PRIORITY_WIDTH{1'b1}};
  localparam logic [PAYLOAD_WIDTH-1:0]  LOAD_MAX = {PAYLOAD_WIDTH{1'b1}};

  // What one result shows of the queue after an item.
  typedef struct {
    spiq_status_t              status;
    logic                      head_valid;
    logic [PRIORITY_WIDTH-1:0] head_prio;
    logic [PAYLOAD_WIDTH-1:0]  head_load;
    logic [PRIORITY_WIDTH-1:0] tail_prio;
    logic [PAYLOAD_WIDTH-1:0]  tail_load;
    logic [COUNT_WIDTH-1:0]    total;
  } queue_view_t;

  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      start            = 1'b0;
  logic [2:0]                in_opcode        = '0;
  logic [PRIORITY_WIDTH-1:0] in_item_priority = '0;
  logic [PAYLOAD_WIDTH-1:0]  in_item_payload  = '0;
  logic                      busy;
  logic                      out_valid;
  logic [1:0]                out_status;
  logic                      out_head_valid;
  logic [PRIORITY_WIDTH-1:0] out_head_priority;
  logic [PAYLOAD_WIDTH-1:0]  out_head_payload;
  logic [PRIORITY_WIDTH-1:0] out_tail_priority;
  logic [PAYLOAD_WIDTH-1:0]  out_tail_payload;
  logic [COUNT_WIDTH-1:0]    out_entry_total;

  // Shadow copy of the queue contents, slot 0 is the head.
  logic [PRIORITY_WIDTH-1:0] shadow_prio [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0]  shadow_load [QUEUE_DEPTH];
  int unsigned               shadow_count = 0;

  queue_view_t pending_views [$];
  queue_view_t oldest_view;

  int unsigned sender_idle_pct  = 0;
  int unsigned stall_cycles     = 0;
  int unsigned error_count      = 0;
  int unsigned items_sent       = 0;
  int unsigned results_checked  = 0;
  int unsigned drops_on_full    = 0;
  int unsigned removes_on_empty = 0;

  always #1 clk = ~clk;

  stable_priority_insert_queue_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_item_priority (in_item_priority),
    .in_item_payload  (in_item_payload),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_head_valid   (out_head_valid),
    .out_head_priority(out_head_priority),
    .out_head_payload (out_head_payload),
    .out_tail_priority(out_tail_priority),
    .out_tail_payload (out_tail_payload),
    .out_entry_total  (out_entry_total)
  );

  // Apply one operation to the shadow queue and return the view the block must report.
  // Unused codes fall through as peek.
  function automatic queue_view_t apply_queue_op(input logic [2:0]                code,
                                                 input logic [PRIORITY_WIDTH-1:0] prio,
                                                 input logic [PAYLOAD_WIDTH-1:0]  load);
    queue_view_t view;
    int unsigned slot;
    int unsigned i;
    view.status = ST_DONE;
    case (code)
      OP_APPEND, OP_INSERT: begin
        if (shadow_count == QUEUE_DEPTH) begin
          view.status = ST_FULL;
          drops_on_full++;
        end else begin
          slot = shadow_count;
          // Insert goes before the first strictly greater priority; ties stay behind.
          if (code == OP_INSERT) begin
            for (i = shadow_count; i > 0; i--) begin
              if (shadow_prio[i-1] > prio) slot = i - 1;
            end
          end
          for (i = shadow_count; i > slot; i--) begin
            shadow_prio[i] = shadow_prio[i-1];
            shadow_load[i] = shadow_load[i-1];
          end
          shadow_prio[slot] = prio;
          shadow_load[slot] = load;
          shadow_count++;
        end
      end
      OP_REMOVE_HEAD, OP_REMOVE_TAIL: begin
        if (shadow_count == 0) begin
          view.status = ST_EMPTY;
          removes_on_empty++;
        end else begin
          if (code == OP_REMOVE_HEAD) begin
            for (i = 0; i + 1 < shadow_count; i++) begin
              shadow_prio[i] = shadow_prio[i+1];
              shadow_load[i] = shadow_load[i+1];
            end
          end
          shadow_count--;
        end
      end
      default: ;
    endcase
    view.total = COUNT_WIDTH'(shadow_count);
    if (shadow_count > 0) begin
      view.head_valid = 1'b1;
      view.head_prio  = shadow_prio[0];
      view.head_load  = shadow_load[0];
      view.tail_prio  = shadow_prio[shadow_count-1];
      view.tail_load  = shadow_load[shadow_count-1];
    end else begin
      view.head_valid = 1'b0;
      view.head_prio  = '0;
      view.head_load  = '0;
      view.tail_prio  = '0;
      view.tail_load  = '0;
    end
    return view;
  endfunction

  // Send one item: idle at random first, then hold start until the block takes it.
  // Leave start high afterwards so back-to-back items need no extra edge.
  task automatic send_item(input logic [2:0]                code,
                           input logic [PRIORITY_WIDTH-1:0] prio,
                           input logic [PAYLOAD_WIDTH-1:0]  load);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(MAX_GAP, 1)) @(negedge clk);
    end
    start            <= 1'b1;
    in_opcode        <= code;
    in_item_priority <= prio;
    in_item_payload  <= load;
    do @(posedge clk); while (busy);
    pending_views.push_back(apply_queue_op(code, prio, load));
    items_sent++;
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic settle_queue();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_views.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Removals and peeks on an empty queue, plus every unused opcode.
  task automatic test_empty_queue();
    int code;
    send_item(OP_PEEK, PRIO_MAX, LOAD_MAX);
    send_item(OP_REMOVE_HEAD, '0, '0);
    send_item(OP_REMOVE_TAIL, PRIO_MAX, LOAD_MAX);
    for (code = int'(OP_PEEK) + 1; code <= int'(3'h7); code++) begin
      send_item(code[2:0], PRIORITY_WIDTH'($urandom), $urandom);
    end
  endtask

  // Check stable ordering on ties and extremes, fill up, push into a full queue, then remove from both ends and peek.
  task automatic test_order_and_overflow();
    send_item(OP_APPEND, 8'h80, '0);
    send_item(OP_INSERT, 8'h80, LOAD_MAX);       // equal priority: lands behind
    send_item(OP_INSERT, '0, 32'h1);             // lowest priority value: new head
    send_item(OP_INSERT, PRIO_MAX, 32'h2);       // highest: tail
    send_item(OP_INSERT, 8'h80, 32'h3);          // behind both 0x80 entries
    send_item(OP_APPEND, '0, 32'h4);             // append ignores priority
    while (shadow_count < QUEUE_DEPTH) begin
      send_item(OP_INSERT, PRIORITY_WIDTH'($urandom_range(3)), $urandom);
    end
    send_item(OP_APPEND, PRIO_MAX, LOAD_MAX);
    send_item(OP_INSERT, '0, LOAD_MAX);
    send_item(OP_REMOVE_HEAD, '0, '0);
    send_item(OP_REMOVE_TAIL, '0, '0);
    send_item(OP_PEEK, '0, '0);
  endtask

  // Random traffic that swings between filling and draining, so both ends get hit often.
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct);
    logic [2:0]                code;
    logic [PRIORITY_WIDTH-1:0] prio;
    bit                        filling;
    int unsigned               roll;
    sender_idle_pct = idle_pct;
    filling = 1'b1;
    repeat (count) begin
      if (shadow_count == QUEUE_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      else if (shadow_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
      else if ($urandom_range(39) == 0) filling = !filling;
      roll = $urandom_range(99);
      if (filling) begin
        if (roll < 40)      code = OP_INSERT;
        else if (roll < 65) code = OP_APPEND;
        else if (roll < 80) code = OP_REMOVE_HEAD;
        else if (roll < 90) code = OP_REMOVE_TAIL;
        else if (roll < 95) code = OP_PEEK;
        else                code = 3'($urandom_range(7, int'(OP_PEEK) + 1));
      end else begin
        if (roll < 15)      code = OP_INSERT;
        else if (roll < 25) code = OP_APPEND;
        else if (roll < 60) code = OP_REMOVE_HEAD;
        else if (roll < 85) code = OP_REMOVE_TAIL;
        else if (roll < 93) code = OP_PEEK;
        else                code = 3'($urandom_range(7, int'(OP_PEEK) + 1));
      end
      // Narrow priorities give plenty of ties; mix in the extremes and full-range values.
      roll = $urandom_range(99);
      if (roll < 40)      prio = PRIORITY_WIDTH'($urandom_range(3));
      else if (roll < 50) prio = $urandom_range(1) ? PRIO_MAX : '0;
      else                prio = PRIORITY_WIDTH'($urandom);
      send_item(code, prio, $urandom);
    end
  endtask

  // Compare every result with the oldest expected view.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_views.size() == 0) begin
        $error("out_valid: result arrived with no item outstanding");
        error_count++;
      end else begin
        oldest_view = pending_views.pop_front();
        compare_field("out_status", 64'(oldest_view.status), 64'(out_status));
        compare_field("out_head_valid", 64'(oldest_view.head_valid), 64'(out_head_valid));
        compare_field("out_head_priority", 64'(oldest_view.head_prio), 64'(out_head_priority));
        compare_field("out_head_payload", 64'(oldest_view.head_load), 64'(out_head_payload));
        compare_field("out_tail_priority", 64'(oldest_view.tail_prio), 64'(out_tail_priority));
        compare_field("out_tail_payload", 64'(oldest_view.tail_load), 64'(out_tail_payload));
        compare_field("out_entry_total", 64'(oldest_view.total), 64'(out_entry_total));
        results_checked++;
      end
    end
  end

  // Count cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    // Hold reset from time zero, then release it on a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 31;
    test_empty_queue();
    test_order_and_overflow();
    settle_queue();

    test_random_traffic(PHASE_ITEMS, 31);
    settle_queue();
    test_random_traffic(PHASE_ITEMS, 49);
    settle_queue();
    test_random_traffic(PHASE_ITEMS, 0);
    settle_queue();

    $display("Sent %0d items over directed and three random phases: %0d pushes into a full %s",
             items_sent, drops_on_full, "queue");
    $display("%0d removals from an empty queue; %0d results checked, %0d mismatches",
             removes_on_empty, results_checked, error_count);
    if (error_count == 0 && pending_views.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
src/spiq_pkg.sv
src/spiq_cell.sv
src/stable_priority_insert_queue_unit.sv
src/spiq_checker.sv
verif/tb_stable_priority_insert_queue_unit.sv
